>>> design/dad_pkg.sv
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, status codes and calendar tables for the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

   // field widths
   localparam int DayW   = 5;
   localparam int MonthW = 4;
   localparam int YearW  = 16;
   localparam int CountW = 9;
   localparam int TotalW = 10;

   // day count limits
   localparam int MaxAddDaysDefault = 300;
   localparam int MaxAddDaysHigh    = 365;

   // reciprocal of 25, exact for every 16-bit year
   localparam int Recip25      = 83887;
   localparam int Recip25Shift = 21;
   localparam int ProdW        = YearW + 17;
   localparam int QuotW        = ProdW - Recip25Shift;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_COUNT,
      STATUS_BAD_MONTH,
      STATUS_BAD_DAY
   } status_type;

   // days before the first of a month, month index 0 is January
   function automatic logic [TotalW-1:0] cum_days(input logic leap,
                                                  input logic [MonthW-1:0] mi);
      logic [TotalW-1:0] base;
      case (mi)
         4'd0:    base = 10'd0;
         4'd1:    base = 10'd31;
         4'd2:    base = 10'd59;
         4'd3:    base = 10'd90;
         4'd4:    base = 10'd120;
         4'd5:    base = 10'd151;
         4'd6:    base = 10'd181;
         4'd7:    base = 10'd212;
         4'd8:    base = 10'd243;
         4'd9:    base = 10'd273;
         4'd10:   base = 10'd304;
         4'd11:   base = 10'd334;
         default: base = 10'd0;
      endcase
      if (leap && (mi >= 4'd2)) begin
         base = base + 10'd1;
      end
      return base;
   endfunction

   // length of a month, february follows the leap flag
   function automatic logic [DayW-1:0] month_len(input logic leap,
                                                 input logic [MonthW-1:0] mi);
      logic [DayW-1:0] len;
      case (mi)
         4'd1:                      len = leap ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> design/dad_leap.sv
// ----------------------------------------------------------------------------
// dad_leap
// Two-stage Gregorian leap year test: reciprocal multiply, then a check for
// divisibility by 25 combined with the low bits of the year.
// ----------------------------------------------------------------------------
module dad_leap (
   input  logic                      clock,
   input  logic [dad_pkg::YearW-1:0] year,
   output logic                      leap
);

   localparam int YearW = dad_pkg::YearW;
   localparam int ProdW = dad_pkg::ProdW;
   localparam int QuotW = dad_pkg::QuotW;

   logic [ProdW-1:0] prod_in, prod_ff;
   logic [YearW-1:0] year_ff;
   logic [QuotW-1:0] quot;
   logic [YearW-1:0] quot_x25;
   logic             div25;
   logic             leap_in, leap_ff;

   // year times the scaled reciprocal of 25
   assign prod_in = ProdW'(year) * ProdW'(dad_pkg::Recip25);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      year_ff <= year;
   end

   // quotient back to a multiple of 25 and compare
   always_comb begin
      quot     = prod_ff[ProdW-1:dad_pkg::Recip25Shift];
      quot_x25 = YearW'(quot) * YearW'(25);
      div25    = (quot_x25 == year_ff);
      // leap: by 4, and not by 100 unless by 400 (by 16 and by 25)
      leap_in  = (year_ff[1:0] == 2'b00) && (!div25 || (year_ff[3:0] == 4'b0000));
   end

   always_ff @(posedge clock) begin
      leap_ff <= leap_in;
   end

   assign leap = leap_ff;

endmodule

>>> design/date_add_days_core.sv
// ----------------------------------------------------------------------------
// date_add_days_core
// Adds a day count to a Gregorian date, with range checks on the inputs.
//
//   channel   ports                                   handshake
//   request   req_start_day/month/year, req_add_days  start, busy
//   result    rsp_end_day/month/year, rsp_status      rsp_strobe, one cycle
//
// One request is taken every cycle while busy is low. The pipeline is the leap
// year unit (multiply, then compare) ahead of the day-of-year add and the month
// search, each a register stage.
// Reset is synchronous and clears the stage valid bits; busy is high while
// reset is held and low otherwise. The receiver cannot stall, so nothing
// inside the pipeline ever waits.
// ----------------------------------------------------------------------------
module date_add_days_core #(
   parameter int MAX_ADD_DAYS = dad_pkg::MaxAddDaysDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [dad_pkg::DayW-1:0]   req_start_day,
   input  logic [dad_pkg::MonthW-1:0] req_start_month,
   input  logic [dad_pkg::YearW-1:0]  req_start_year,
   input  logic [dad_pkg::CountW-1:0] req_add_days,
   output logic                       rsp_strobe,
   output logic [dad_pkg::DayW-1:0]   rsp_end_day,
   output logic [dad_pkg::MonthW-1:0] rsp_end_month,
   output logic [dad_pkg::YearW-1:0]  rsp_end_year,
   output logic [1:0]                 rsp_status
);

   localparam int DayW   = dad_pkg::DayW;
   localparam int MonthW = dad_pkg::MonthW;
   localparam int YearW  = dad_pkg::YearW;
   localparam int CountW = dad_pkg::CountW;
   localparam int TotalW = dad_pkg::TotalW;
   localparam logic [CountW-1:0] MaxAdd = CountW'(MAX_ADD_DAYS);

   logic accept;

   // stage 1 registers
   logic              valid1_ff;
   logic [DayW-1:0]   day1_ff;
   logic [MonthW-1:0] month1_ff;
   logic [YearW-1:0]  year1_ff;
   logic [CountW-1:0] count1_ff;

   // stage 2 registers
   logic                valid2_ff;
   logic [DayW-1:0]     day2_ff;
   logic [MonthW-1:0]   mi2_ff;
   logic [YearW-1:0]    year2_ff;
   logic [CountW-1:0]   count2_ff;
   dad_pkg::status_type status2_in, status2_ff;
   logic                leap_cur, leap_next;

   // stage 3 registers
   logic                valid3_ff;
   dad_pkg::status_type status3_in, status3_ff;
   logic [TotalW-1:0]   total3_in, total3_ff;
   logic [YearW-1:0]    year3_in, year3_ff;
   logic                leap3_in, leap3_ff;
   logic [DayW-1:0]     mlen;
   logic [TotalW-1:0]   doy;
   logic [TotalW-1:0]   ylen;

   // stage 4 (output) registers
   logic                strobe_ff;
   logic [DayW-1:0]     end_day_in, end_day_ff;
   logic [MonthW-1:0]   end_month_in, end_month_ff;
   logic [YearW-1:0]    end_year_in, end_year_ff;
   dad_pkg::status_type status4_ff;
   logic [MonthW-1:0]   k;
   logic [TotalW-1:0]   day_full;

   assign busy   = reset;
   assign accept = start && !busy;

   // stage 1: capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= accept;
      end
      day1_ff   <= req_start_day;
      month1_ff <= req_start_month;
      year1_ff  <= req_start_year;
      count1_ff <= req_add_days;
   end

   // leap status of this year and the next, ready in stage 2
   dad_leap u_leap_cur (
      .clock (clock),
      .year  (req_start_year),
      .leap  (leap_cur)
   );

   dad_leap u_leap_next (
      .clock (clock),
      .year  (req_start_year + YearW'(1)),
      .leap  (leap_next)
   );

   // stage 2: count and month checks
   always_comb begin
      if (count1_ff > MaxAdd) begin
         status2_in = dad_pkg::STATUS_BAD_COUNT;
      end else if ((month1_ff == MonthW'(0)) || (month1_ff > MonthW'(12))) begin
         status2_in = dad_pkg::STATUS_BAD_MONTH;
      end else begin
         status2_in = dad_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
      day2_ff    <= day1_ff;
      mi2_ff     <= month1_ff - MonthW'(1);
      year2_ff   <= year1_ff;
      count2_ff  <= count1_ff;
      status2_ff <= status2_in;
   end

   // stage 3: day check, day of year plus count, year rollover
   always_comb begin
      mlen = dad_pkg::month_len(leap_cur, mi2_ff);
      if ((status2_ff == dad_pkg::STATUS_OK) &&
          ((day2_ff == DayW'(0)) || (day2_ff > mlen))) begin
         status3_in = dad_pkg::STATUS_BAD_DAY;
      end else begin
         status3_in = status2_ff;
      end
      doy  = dad_pkg::cum_days(leap_cur, mi2_ff) + TotalW'(day2_ff) + TotalW'(count2_ff);
      ylen = leap_cur ? TotalW'(366) : TotalW'(365);
      if (doy > ylen) begin
         total3_in = doy - ylen;
         year3_in  = year2_ff + YearW'(1);
         leap3_in  = leap_next;
      end else begin
         total3_in = doy;
         year3_in  = year2_ff;
         leap3_in  = leap_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
      status3_ff <= status3_in;
      total3_ff  <= total3_in;
      year3_ff   <= year3_in;
      leap3_ff   <= leap3_in;
   end

   // stage 4: month search over the cumulative table, error zeroing
   always_comb begin
      k = MonthW'(0);
      for (int j = 1; j < 12; j++) begin
         if (total3_ff > dad_pkg::cum_days(leap3_ff, MonthW'(j))) begin
            k = MonthW'(j);
         end
      end
      day_full = total3_ff - dad_pkg::cum_days(leap3_ff, k);
      if (status3_ff == dad_pkg::STATUS_OK) begin
         end_day_in   = day_full[DayW-1:0];
         end_month_in = k + MonthW'(1);
         end_year_in  = year3_ff;
      end else begin
         end_day_in   = '0;
         end_month_in = '0;
         end_year_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= valid3_ff;
      end
      end_day_ff   <= end_day_in;
      end_month_ff <= end_month_in;
      end_year_ff  <= end_year_in;
      status4_ff   <= status3_ff;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_end_day   = end_day_ff;
   assign rsp_end_month = end_month_ff;
   assign rsp_end_year  = end_year_ff;
   assign rsp_status    = status4_ff;

endmodule

>>> design/dad_checker.sv
// ----------------------------------------------------------------------------
// dad_checker
// Port-level checks on the date adder: latency, spurious results, error
// zeroing, result ranges and count rejection.
// ----------------------------------------------------------------------------
module dad_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic [dad_pkg::CountW-1:0] req_add_days,
   input logic                       rsp_strobe,
   input logic [dad_pkg::DayW-1:0]   rsp_end_day,
   input logic [dad_pkg::MonthW-1:0] rsp_end_month,
   input logic [dad_pkg::YearW-1:0]  rsp_end_year,
   input logic [1:0]                 rsp_status
);

   // every accepted request gives a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result missing four cycles after request");

   // no result without an earlier accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 4))
      else $error("result without a matching request");

   // error results carry zero date fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != dad_pkg::STATUS_OK)) |->
      ((rsp_end_day == '0) && (rsp_end_month == '0) && (rsp_end_year == '0)))
      else $error("error result with nonzero date");

   // good results hold a real month and day
   a_ok_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == dad_pkg::STATUS_OK)) |->
      ((rsp_end_day != '0) && (rsp_end_month != '0) && (rsp_end_month <= 4'd12)))
      else $error("good result out of calendar range");

   // a count beyond any allowed limit is always rejected
   a_count_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && ($past(req_add_days, 4) > dad_pkg::CountW'(dad_pkg::MaxAddDaysHigh)))
      |-> (rsp_status == dad_pkg::STATUS_BAD_COUNT))
      else $error("oversized day count not rejected");

endmodule

bind date_add_days_core dad_checker u_dad_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_add_days  (req_add_days),
   .rsp_strobe    (rsp_strobe),
   .rsp_end_day   (rsp_end_day),
   .rsp_end_month (rsp_end_month),
   .rsp_end_year  (rsp_end_year),
   .rsp_status    (rsp_status)
);
